/* rtl/rspe_pkg.sv */
package rspe_pkg;

    localparam int CODE_BITS_DEF  = 34;
    localparam int CODE_COUNT_DEF = 10;
    localparam int ROM_WIDTH      = 64;

    // configuration register indexes
    localparam logic [2:0] CFG_UNIT_TICKS  = 3'd0;
    localparam logic [2:0] CFG_SHORT_UNITS = 3'd1;
    localparam logic [2:0] CFG_LONG_UNITS  = 3'd2;
    localparam logic [2:0] CFG_PAUSE_UNITS = 3'd3;
    localparam logic [2:0] CFG_SYNC_UNITS  = 3'd4;
    localparam logic [2:0] CFG_REPEAT      = 3'd5;

    localparam logic [2:0] CHANNEL_ALL = 3'd4;

    typedef enum logic [1:0] {
        PH_HIGH,
        PH_LOW,
        PH_SYNC,
        PH_PAUSE
    } t_phase;

    typedef enum logic [1:0] {
        ST_NONE,
        ST_ACCEPTED,
        ST_BUSY,
        ST_INVALID
    } t_status;

    function automatic logic [ROM_WIDTH-1:0] code_rom(input logic [3:0] sel);
        logic [ROM_WIDTH-1:0] v;
        case (sel)
            4'd0:    v = 64'h727E0E3C << 2;
            4'd1:    v = 64'h727E0F3D << 2;
            4'd2:    v = 64'h727E0C3F << 2;
            4'd3:    v = 64'h727E0D3E << 2;
            4'd4:    v = 64'h727E0A38 << 2;
            4'd5:    v = 64'h727E0B39 << 2;
            4'd6:    v = 64'h727E0634 << 2;
            4'd7:    v = 64'h727E0735 << 2;
            4'd8:    v = 64'h727E083B << 2;
            4'd9:    v = 64'h727E0437 << 2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/remote_socket_pulse_encoder.sv */
// an accepted request's result is registered in the output register
// throughput: one request per cycle unless the output stalls; the output register lets the next request in
// while the current result is taken (s_axis_tready = !r_out_valid || m_axis_tready)
// each tick request costs only counter updates; segment changes resolve in the same cycle
// reset (synchronous, active low): transmitter idle, output register empty,
// configuration back to its defaults
module remote_socket_pulse_encoder #(
    parameter int CODE_BITS  = rspe_pkg::CODE_BITS_DEF,
    parameter int CODE_COUNT = rspe_pkg::CODE_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [2:0] channel, [3] switch_off, [7:4] zero
    input  logic        s_axis_tuser,   // [0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] line_level, [1] power_enable, [2] busy_res,
                                        // [4:3] start_status, [7:5] zero
    output logic        m_axis_tlast,   // finished
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);
    import rspe_pkg::*;

    localparam int BW = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;
    localparam logic [BW-1:0] LastBit = BW'(CODE_BITS - 1);

    // configuration
    logic [19:0] r_unit_ticks;
    logic [3:0]  r_short_units, r_long_units, r_sync_units, r_repeat;
    logic [5:0]  r_pause_units;

    // transmitter state
    logic                 r_active, n_active;
    logic [CODE_BITS-1:0] r_code, n_code;
    logic [BW-1:0]        r_bit, n_bit;
    logic [3:0]           r_copies, n_copies;
    t_phase               r_phase, n_phase;
    logic [5:0]           r_units, n_units;
    logic [19:0]          r_ticks, n_ticks;
    t_status              n_status;
    logic                 n_finished;

    // output register
    logic    r_out_valid;
    logic    r_line, r_power, r_busy, r_finished;
    t_status r_status;
    logic    n_line;

    logic       s_accept, cfg_accept;
    logic [3:0] sel;
    logic [5:0] short_u, long_u;
    logic [19:0] unit_t;
    logic [ROM_WIDTH-1:0] rom_word;
    logic [CODE_BITS-1:0] rot_code, rom_code;

    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign cfg_accept    = i_cfg_valid;

    assign sel      = {s_axis_tdata[2:0], s_axis_tdata[3]};
    assign short_u  = (r_short_units == 4'd0) ? 6'd1 : {2'b00, r_short_units};
    assign long_u   = (r_long_units == 4'd0) ? 6'd1 : {2'b00, r_long_units};
    assign unit_t   = (r_unit_ticks == 20'd0) ? 20'd1 : r_unit_ticks;
    assign rot_code = (r_code << 1) | (r_code >> (CODE_BITS - 1));
    assign rom_word = code_rom(sel);
    assign rom_code = rom_word[CODE_BITS-1:0];

    // next state
    always_comb begin
        logic seg_end, to_sync, to_pause, to_copy;
        n_active   = r_active;
        n_code     = r_code;
        n_bit      = r_bit;
        n_copies   = r_copies;
        n_phase    = r_phase;
        n_units    = r_units;
        n_ticks    = r_ticks;
        n_status   = ST_NONE;
        n_finished = 1'b0;
        seg_end    = 1'b0;
        to_sync    = 1'b0;
        to_pause   = 1'b0;
        to_copy    = 1'b0;
        if (s_axis_tuser) begin
            if (r_active) begin
                n_status = ST_BUSY;
            end else if (s_axis_tdata[2:0] > CHANNEL_ALL ||
                         {1'b0, sel} >= 5'(CODE_COUNT)) begin
                n_status = ST_INVALID;
            end else begin
                n_status = ST_ACCEPTED;
                n_active = 1'b1;
                n_code   = rom_code;
                n_bit    = '0;
                n_copies = (r_repeat == 4'd0) ? 4'd1 : r_repeat;
                n_phase  = PH_HIGH;
                n_units  = rom_code[CODE_BITS-1] ? long_u : short_u;
                n_ticks  = unit_t;
            end
        end else if (r_active) begin
            n_ticks = r_ticks - 20'd1;
            if (n_ticks == 20'd0) begin
                n_units = r_units - 6'd1;
                if (n_units == 6'd0) begin
                    seg_end = 1'b1;
                end else begin
                    n_ticks = unit_t;
                end
            end
        end

        if (seg_end) begin
            n_ticks = unit_t;
            case (r_phase)
                PH_HIGH: begin
                    n_phase = PH_LOW;
                    n_units = r_code[CODE_BITS-1] ? short_u : long_u;
                end
                PH_LOW: begin
                    n_code = rot_code;
                    if (r_bit == LastBit) begin
                        to_sync = 1'b1;
                    end else begin
                        n_bit   = r_bit + 1'b1;
                        n_phase = PH_HIGH;
                        n_units = rot_code[CODE_BITS-1] ? long_u : short_u;
                    end
                end
                PH_SYNC:  to_pause = 1'b1;
                default:  to_copy  = 1'b1;
            endcase
            // zero-length sync or pause segments are skipped
            if (to_sync) begin
                if (r_sync_units != 4'd0) begin
                    n_phase = PH_SYNC;
                    n_units = {2'b00, r_sync_units};
                end else begin
                    to_pause = 1'b1;
                end
            end
            if (to_pause) begin
                if (r_pause_units != 6'd0) begin
                    n_phase = PH_PAUSE;
                    n_units = r_pause_units;
                end else begin
                    to_copy = 1'b1;
                end
            end
            if (to_copy) begin
                n_copies = r_copies - 4'd1;
                if (n_copies == 4'd0) begin
                    n_finished = 1'b1;
                    n_active   = 1'b0;
                    n_bit      = '0;
                    n_phase    = PH_HIGH;
                    n_units    = 6'd0;
                    n_ticks    = 20'd0;
                end else begin
                    n_bit   = '0;
                    n_phase = PH_HIGH;
                    n_units = n_code[CODE_BITS-1] ? long_u : short_u;
                end
            end
        end
    end

    // result values
    always_comb begin
        n_line = n_active && (n_phase == PH_HIGH || n_phase == PH_SYNC);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_ticks  <= 20'd1;
            r_short_units <= 4'd1;
            r_long_units  <= 4'd3;
            r_pause_units <= 6'd29;
            r_sync_units  <= 4'd0;
            r_repeat      <= 4'd8;
        end else if (cfg_accept) begin
            case (i_cfg_index)
                CFG_UNIT_TICKS:  r_unit_ticks  <= i_cfg_data;
                CFG_SHORT_UNITS: r_short_units <= i_cfg_data[3:0];
                CFG_LONG_UNITS:  r_long_units  <= i_cfg_data[3:0];
                CFG_PAUSE_UNITS: r_pause_units <= i_cfg_data[5:0];
                CFG_SYNC_UNITS:  r_sync_units  <= i_cfg_data[3:0];
                CFG_REPEAT:      r_repeat      <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_bit       <= '0;
            r_copies    <= 4'd0;
            r_phase     <= PH_HIGH;
            r_units     <= 6'd0;
            r_ticks     <= 20'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_active    <= n_active;
                r_bit       <= n_bit;
                r_copies    <= n_copies;
                r_phase     <= n_phase;
                r_units     <= n_units;
                r_ticks     <= n_ticks;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_code     <= n_code;
            r_line     <= n_line;
            r_power    <= n_active;
            r_busy     <= n_active;
            r_status   <= n_status;
            r_finished <= n_finished;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_status, r_busy, r_power, r_line};
    assign m_axis_tlast  = r_finished;

    a_units_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_units != 6'd0 && r_ticks != 20'd0))
        else $error("active transmitter with an empty segment counter");

    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_finished) |-> (!r_busy && !r_line))
        else $error("finished result while still busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_ACCEPTED) |-> (r_busy && r_power))
        else $error("accepted start did not make the block busy");

    a_refuse_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && s_axis_tuser && r_active) |=> (r_active && $stable(r_units)
                                                    && $stable(r_phase)))
        else $error("refused start disturbed the transmission");

    a_idle_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_bit == '0 && r_copies == 4'd0))
        else $error("idle transmitter holds stale counters");

endmodule
